// ===== rtl/core/mspg_pkg.sv =====
package mspg_pkg;

    localparam int unsigned NumChannelsDefault = 10;
    localparam logic [31:0] InvTwoPi = 32'd683565276;
    localparam logic signed [32:0] SinA1 = 33'sd1686629713;
    localparam logic signed [32:0] SinA3 = 33'sd693598668;
    localparam logic signed [32:0] SinA5 = 33'sd85569306;
    localparam logic signed [32:0] SinA7 = 33'sd5026995;
    localparam logic signed [32:0] SinA9 = 33'sd172272;
    localparam logic [30:0] Q30One = 31'h4000_0000;

    localparam logic [1:0] CfgMinLength    = 2'd0;
    localparam logic [1:0] CfgMaxLength    = 2'd1;
    localparam logic [1:0] CfgTimeStep     = 2'd2;
    localparam logic [1:0] CfgClusterCount = 2'd3;

    localparam logic [1:0] ClampNone = 2'd0;
    localparam logic [1:0] ClampMin  = 2'd1;
    localparam logic [1:0] ClampMax  = 2'd2;

    localparam logic OpLoad = 1'b0;
    localparam logic OpTick = 1'b1;

    // datapath micro-ops, one per controller state
    typedef enum logic [4:0] {
        S_IDLE,
        S_LOAD,
        S_ADV_RD,
        S_ADV_M1,
        S_ADV_M2L,
        S_ADV_M2H,
        S_ADV_WR,
        S_CH_RD,
        S_PH_MUL,
        S_ANG,
        S_X2,
        S_H1,
        S_H2,
        S_H3,
        S_H4,
        S_HX,
        S_AMP,
        S_LEN,
        S_OUT
    } t_state;

    typedef struct packed {
        t_state op;
        logic   restart_phase;
    } t_cmd;

    typedef struct packed {
        logic restart_hit;
        logic last_ch;
    } t_status;

endpackage

// ===== rtl/core/multichannel_sine_pattern_generator_top.sv =====
// Bank of NUM_CHANNELS sine generators. A load item (opcode 0) writes one
// channel's amplitude, rate, phase step and offset. A tick (opcode 1)
// advances all angles, then emits one clamped target length per channel in
// order, holding each result under output stalls. The controller steps the
// shared datapath through its micro-ops, one state at a time.
module multichannel_sine_pattern_generator_top #(
    parameter int unsigned NUM_CHANNELS = mspg_pkg::NumChannelsDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_opcode,
    input  logic [3:0]          i_load_channel,
    input  logic signed [31:0]  i_load_amplitude,
    input  logic [23:0]         i_load_rate,
    input  logic signed [18:0]  i_load_phase_step,
    input  logic signed [31:0]  i_load_offset,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [3:0]          o_out_channel,
    output logic signed [31:0]  o_target_length,
    output logic [1:0]          o_clamp_state,
    output logic                o_last,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import mspg_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_accept;
    logic    w_take;

    assign o_cfg_ready = 1'b1;
    assign w_accept = i_valid && !o_stall && (i_opcode == OpLoad);
    assign w_take = !o_valid || !i_stall;

    mspg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_opcode    (i_opcode),
        .i_out_stall (i_stall),
        .i_status    (w_status),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid),
        .o_cmd       (w_cmd)
    );

    mspg_dp #(.NUM_CHANNELS(NUM_CHANNELS)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_in_accept       (w_accept),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_load_channel    (i_load_channel),
        .i_load_amplitude  (i_load_amplitude),
        .i_load_rate       (i_load_rate),
        .i_load_phase_step (i_load_phase_step),
        .i_load_offset     (i_load_offset),
        .i_out_take        (w_take),
        .o_status          (w_status),
        .o_out_channel     (o_out_channel),
        .o_target_length   (o_target_length),
        .o_clamp_state     (o_clamp_state),
        .o_last            (o_last)
    );
endmodule

// ===== rtl/core/mspg_ctrl.sv =====
module mspg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_opcode,
    input  logic              i_out_stall,
    input  mspg_pkg::t_status i_status,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output mspg_pkg::t_cmd    o_cmd
);
    import mspg_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_opcode == OpTick) ? S_ADV_RD : S_LOAD;
                end
            end
            S_LOAD:    n_state = S_IDLE;
            S_ADV_RD:  n_state = S_ADV_M1;
            S_ADV_M1:  n_state = S_ADV_M2L;
            S_ADV_M2L: n_state = S_ADV_M2H;
            S_ADV_M2H: n_state = S_ADV_WR;
            S_ADV_WR:  n_state = i_status.last_ch ? S_CH_RD : S_ADV_RD;
            S_CH_RD:   n_state = S_PH_MUL;
            S_PH_MUL:  n_state = S_ANG;
            S_ANG:     n_state = S_X2;
            S_X2:      n_state = S_H1;
            S_H1:      n_state = S_H2;
            S_H2:      n_state = S_H3;
            S_H3:      n_state = S_H4;
            S_H4:      n_state = S_HX;
            S_HX:      n_state = S_AMP;
            S_AMP:     n_state = S_LEN;
            S_LEN:     n_state = S_OUT;
            S_OUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_state = i_status.last_ch ? S_IDLE : S_CH_RD;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op = r_state;
        o_cmd.restart_phase = (r_state == S_CH_RD) && i_status.restart_hit;
        o_in_stall = (r_state != S_IDLE);
        o_out_valid = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("input taken while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("result dropped under stall");
    a_load_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |=> (r_state == S_IDLE))
        else $error("load did not finish");
    a_out_only_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("result raised outside emit");
`endif
endmodule

// ===== rtl/core/mspg_dp.sv =====
module mspg_dp #(
    parameter int unsigned NUM_CHANNELS = mspg_pkg::NumChannelsDefault
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mspg_pkg::t_cmd       i_cmd,
    input  logic                 i_in_accept,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic [3:0]           i_load_channel,
    input  logic signed [31:0]   i_load_amplitude,
    input  logic [23:0]          i_load_rate,
    input  logic signed [18:0]   i_load_phase_step,
    input  logic signed [31:0]   i_load_offset,
    input  logic                 i_out_take,
    output mspg_pkg::t_status    o_status,
    output logic [3:0]           o_out_channel,
    output logic signed [31:0]   o_target_length,
    output logic [1:0]           o_clamp_state,
    output logic                 o_last
);
    import mspg_pkg::*;

    localparam int unsigned ChW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic signed [31:0] r_amp [NUM_CHANNELS];
    logic [23:0]        r_rate [NUM_CHANNELS];
    logic signed [18:0] r_pstep [NUM_CHANNELS];
    logic signed [31:0] r_off [NUM_CHANNELS];
    logic [31:0]        r_acc [NUM_CHANNELS];

    logic signed [31:0] r_min_len, r_max_len;
    logic [31:0]        r_dt;
    logic [3:0]         r_cluster;

    logic [ChW-1:0]     r_ch;
    logic [ChW-1:0]     r_ch_idx;
    logic signed [22:0] r_phase;
    logic [23:0]        r_rate_c;
    logic [55:0]        r_prod;
    logic [63:0]        r_t;
    logic [31:0]        r_step;
    logic signed [54:0] r_pturn;
    logic [31:0]        w_ang;
    logic [1:0]         r_quad;
    logic [30:0]        r_x;
    logic [30:0]        r_x2;
    logic signed [32:0] r_p;
    logic signed [63:0] r_len;
    logic [31:0]        r_acc_c;
    logic signed [31:0] r_amp_c, r_off_c;
    logic signed [18:0] r_pstep_c;

    logic [3:0]         r_o_ch;
    logic signed [31:0] r_o_len;
    logic [1:0]         r_o_state;
    logic               r_o_last;

    logic [3:0]         w_ch_ext;
    logic [30:0]        w_mul_b;
    logic signed [32:0] w_mul_a;
    logic [63:0]        w_mag_prod;
    logic [32:0]        w_mag;
    logic signed [32:0] w_mq;
    logic signed [32:0] w_coef;
    logic signed [31:0] w_sine;
    logic signed [63:0] w_len_sum;

    assign w_ch_ext = 4'(r_ch);
    assign r_ch_idx = r_ch;
    assign w_ang = r_acc_c + 32'(r_pturn >>> 16);

    // shared signed-by-unsigned q30 multiply, truncated toward zero
    always_comb begin
        w_mul_a = r_p;
        w_mul_b = (i_cmd.op == S_HX) ? r_x : r_x2;
        w_mag = w_mul_a[32] ? 33'(-w_mul_a) : 33'(w_mul_a);
        w_mag_prod = 64'(w_mag) * 64'(w_mul_b);
        w_mq = w_mul_a[32] ? -33'(w_mag_prod >> 30) : 33'(w_mag_prod >> 30);
        unique case (i_cmd.op)
            S_H1:    w_coef = -SinA7;
            S_H2:    w_coef = SinA5;
            S_H3:    w_coef = -SinA3;
            S_H4:    w_coef = SinA1;
            default: w_coef = '0;
        endcase
        if (r_p < 0) begin
            w_sine = '0;
        end else if (r_p > 33'sd1073741824) begin
            w_sine = 32'sd1073741824;
        end else begin
            w_sine = 32'(r_p);
        end
        if (r_quad[1]) begin
            w_sine = -w_sine;
        end
        w_len_sum = (r_len >>> 30) + 64'(r_off_c);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= '0;
            r_max_len <= 32'sh7fff_ffff;
            r_dt <= 32'd6554;
            r_cluster <= 4'd8;
            r_ch <= '0;
            r_phase <= '0;
            r_o_ch <= '0;
            r_o_len <= '0;
            r_o_state <= ClampNone;
            r_o_last <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_amp[i] <= '0;
                r_rate[i] <= '0;
                r_pstep[i] <= '0;
                r_off[i] <= '0;
                r_acc[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CfgMinLength:    r_min_len <= i_cfg_data;
                    CfgMaxLength:    r_max_len <= i_cfg_data;
                    CfgTimeStep:     r_dt <= i_cfg_data;
                    CfgClusterCount: r_cluster <= i_cfg_data[3:0];
                    default:         r_cluster <= r_cluster;
                endcase
            end
            if (i_in_accept && (32'(i_load_channel) < NUM_CHANNELS)) begin
                r_amp[i_load_channel[ChW-1:0]] <= i_load_amplitude;
                r_rate[i_load_channel[ChW-1:0]] <= i_load_rate;
                r_pstep[i_load_channel[ChW-1:0]] <= i_load_phase_step;
                r_off[i_load_channel[ChW-1:0]] <= i_load_offset;
            end
            unique case (i_cmd.op)
                S_IDLE: begin
                    r_ch <= '0;
                    r_phase <= '0;
                end
                S_ADV_RD: begin
                    r_rate_c <= r_rate[r_ch_idx];
                    r_acc_c <= r_acc[r_ch_idx];
                end
                S_ADV_M1:  r_prod <= 56'(r_rate_c) * 56'(r_dt);
                S_ADV_M2L: r_t <= 64'(r_prod[31:0]) * 64'(InvTwoPi);
                S_ADV_M2H: r_step <= 32'((64'(r_prod[55:32]) * 64'(InvTwoPi)
                                         + (r_t >> 32)) >> 16);
                S_ADV_WR: begin
                    r_acc[r_ch_idx] <= r_acc_c + r_step;
                    r_ch <= (32'(r_ch) == NUM_CHANNELS - 1) ? '0 : r_ch + 1'b1;
                end
                S_CH_RD: begin
                    r_acc_c <= r_acc[r_ch_idx];
                    r_amp_c <= r_amp[r_ch_idx];
                    r_off_c <= r_off[r_ch_idx];
                    r_pstep_c <= r_pstep[r_ch_idx];
                    if (i_cmd.restart_phase) begin
                        r_phase <= '0;
                    end
                end
                S_PH_MUL: r_pturn <= 55'(r_phase) * $signed({1'b0, InvTwoPi});
                S_ANG: begin
                    r_quad <= w_ang[31:30];
                    r_x <= w_ang[30] ? (Q30One - 31'(w_ang[29:0])) : 31'(w_ang[29:0]);
                end
                S_X2: begin
                    r_x2 <= 31'((62'(r_x) * 62'(r_x)) >> 30);
                    r_p <= SinA9;
                end
                S_H1, S_H2, S_H3, S_H4: r_p <= w_coef + w_mq;
                S_HX:  r_p <= w_mq;
                S_AMP: r_len <= 64'(r_amp_c) * 64'(w_sine);
                S_LEN: r_len <= w_len_sum;
                S_OUT: begin
                    if (i_out_take) begin
                        r_o_ch <= w_ch_ext;
                        r_o_last <= (32'(r_ch) == NUM_CHANNELS - 1);
                        if (r_len <= 64'(r_min_len)) begin
                            r_o_len <= r_min_len;
                            r_o_state <= ClampMin;
                        end else if (r_len >= 64'(r_max_len)) begin
                            r_o_len <= r_max_len;
                            r_o_state <= ClampMax;
                        end else begin
                            r_o_len <= 32'(r_len);
                            r_o_state <= ClampNone;
                        end
                        r_phase <= r_phase + 23'(r_pstep_c);
                        r_ch <= (32'(r_ch) == NUM_CHANNELS - 1) ? '0 : r_ch + 1'b1;
                    end
                end
                default: r_ch <= r_ch;
            endcase
        end
    end

    assign o_status.last_ch = (32'(r_ch) == NUM_CHANNELS - 1);
    assign o_status.restart_hit = (w_ch_ext == r_cluster);
    assign o_out_channel = r_o_ch;
    assign o_target_length = r_o_len;
    assign o_clamp_state = r_o_state;
    assign o_last = r_o_last;

`ifndef NO_ASSERTIONS
    a_ch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_ch) < NUM_CHANNELS)
        else $error("channel counter out of range");
    a_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == S_X2) |-> (r_x <= Q30One))
        else $error("reduced angle out of range");
    a_clamp_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_state != 2'd3)
        else $error("bad clamp state");
`endif
endmodule

// ===== tb/tb_multichannel_sine_pattern_generator_top.sv =====
`timescale 1ns / 100ps

module tb_multichannel_sine_pattern_generator_top;
    import mspg_pkg::*;

    localparam int unsigned NCH = 10;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned SETTLE_CYCLES = 400;

    typedef struct {
        logic              op;
        logic [3:0]        ch;
        logic signed [31:0] amp;
        logic [23:0]       rate;
        logic signed [18:0] phase_step;
        logic signed [31:0] offset;
    } t_item;

    typedef struct {
        logic [3:0]         ch;
        logic signed [31:0] length;
        logic [1:0]         clamp;
        logic               last;
    } t_target;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic i_opcode = OpLoad;
    logic [3:0] i_load_channel = '0;
    logic signed [31:0] i_load_amplitude = '0;
    logic [23:0] i_load_rate = '0;
    logic signed [18:0] i_load_phase_step = '0;
    logic signed [31:0] i_load_offset = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [3:0] o_out_channel;
    logic signed [31:0] o_target_length;
    logic [1:0] o_clamp_state;
    logic o_last;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [1:0] i_cfg_index = CfgMinLength;
    logic [31:0] i_cfg_data = '0;

    multichannel_sine_pattern_generator_top i_dut (.*);

    // generator model state
    longint min_len, max_len;
    logic [31:0] step_time;
    logic [3:0] restart_ch;
    longint amp_tab[NCH];
    logic [23:0] rate_tab[NCH];
    longint phase_tab[NCH];
    longint offset_tab[NCH];
    logic [31:0] angle_tab[NCH];

    t_item stim_q[$];
    t_target targets_q[$];
    t_item on_bus;
    int gap_cnt = 0;
    int stall_cnt = 0;
    bit hold = 1'b0;
    bit quiet = 1'b0;
    int errors = 0;
    int unsigned cycles = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    task automatic queue_stim(t_item it);
        stim_q.insert(stim_q.size(), it);
    endtask

    task automatic queue_target(t_target t);
        targets_q.insert(targets_q.size(), t);
    endtask

    function automatic longint mul_q30(longint a, longint b);
        longint m;
        m = (a < 0) ? -a : a;
        m = (m * b) >>> 30;
        return (a < 0) ? -m : m;
    endfunction

    function automatic longint sine_q30(logic [31:0] ang);
        longint frac, x, x2, p;
        frac = longint'(ang[29:0]);
        x = ang[30] ? (longint'(1) << 30) - frac : frac;
        x2 = (x * x) >>> 30;
        p = longint'(SinA9);
        p = -longint'(SinA7) + mul_q30(p, x2);
        p = longint'(SinA5) + mul_q30(p, x2);
        p = -longint'(SinA3) + mul_q30(p, x2);
        p = longint'(SinA1) + mul_q30(p, x2);
        p = mul_q30(p, x);
        if (p < 0) p = 0;
        if (p > (longint'(1) << 30)) p = longint'(1) << 30;
        return ang[31] ? -p : p;
    endfunction

    function automatic logic [31:0] angle_advance(logic [23:0] rate, logic [31:0] dt);
        logic [63:0] prod, t, s;
        prod = 64'(rate) * 64'(dt);
        t = 64'(prod[31:0]) * 64'(InvTwoPi);
        s = 64'(prod[63:32]) * 64'(InvTwoPi) + (t >> 32);
        return s[47:16];
    endfunction

    task automatic reset_model();
        min_len = 0;
        max_len = 64'sd2147483647;
        step_time = 32'd6554;
        restart_ch = 4'd8;
        for (int c = 0; c < NCH; c++) begin
            amp_tab[c] = 0;
            rate_tab[c] = '0;
            phase_tab[c] = 0;
            offset_tab[c] = 0;
            angle_tab[c] = '0;
        end
    endtask

    task automatic predict_targets(t_item it);
        longint phase, v, p;
        logic [31:0] ang;
        t_target t;
        if (it.op == OpLoad) begin
            if (it.ch < NCH) begin
                amp_tab[it.ch] = longint'(it.amp);
                rate_tab[it.ch] = it.rate;
                phase_tab[it.ch] = longint'(it.phase_step);
                offset_tab[it.ch] = longint'(it.offset);
            end
        end else begin
            phase = 0;
            for (int c = 0; c < NCH; c++)
                angle_tab[c] = angle_tab[c] + angle_advance(rate_tab[c], step_time);
            for (int c = 0; c < NCH; c++) begin
                if (c == restart_ch) phase = 0;
                p = (phase * longint'(InvTwoPi)) >>> 16;
                ang = angle_tab[c] + p[31:0];
                v = ((amp_tab[c] * sine_q30(ang)) >>> 30) + offset_tab[c];
                t.clamp = ClampNone;
                if (v <= min_len) begin
                    v = min_len;
                    t.clamp = ClampMin;
                end else if (v >= max_len) begin
                    v = max_len;
                    t.clamp = ClampMax;
                end
                t.ch = 4'(c);
                t.length = v[31:0];
                t.last = (c == NCH - 1);
                queue_target(t);
                phase += phase_tab[c];
            end
        end
    endtask

    // sender
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) predict_targets(on_bus);
            if (!i_valid || !o_stall) begin
                if (gap_cnt > 0) begin
                    gap_cnt--;
                    i_valid <= 1'b0;
                end else if (!hold && stim_q.size() > 0) begin
                    on_bus = stim_q.pop_front();
                    i_opcode <= on_bus.op;
                    i_load_channel <= on_bus.ch;
                    i_load_amplitude <= on_bus.amp;
                    i_load_rate <= on_bus.rate;
                    i_load_phase_step <= on_bus.phase_step;
                    i_load_offset <= on_bus.offset;
                    i_valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 4) == 0) gap_cnt = $urandom_range(1, 10);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        t_target exp_t;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (targets_q.size() == 0) begin
                    $error("unexpected transfer: channel %0d length %0d",
                           o_out_channel, o_target_length);
                    errors++;
                end else begin
                    exp_t = targets_q.pop_front();
                    if (o_out_channel !== exp_t.ch) begin
                        $error("out_channel: expected %0d actual %0d", exp_t.ch, o_out_channel);
                        errors++;
                    end
                    if (o_target_length !== exp_t.length) begin
                        $error("target_length: expected %0d actual %0d",
                               exp_t.length, o_target_length);
                        errors++;
                    end
                    if (o_clamp_state !== exp_t.clamp) begin
                        $error("clamp_state: expected %0d actual %0d",
                               exp_t.clamp, o_clamp_state);
                        errors++;
                    end
                    if (o_last !== exp_t.last) begin
                        $error("last: expected %0d actual %0d", exp_t.last, o_last);
                        errors++;
                    end
                end
            end
            if (stall_cnt > 0) begin
                stall_cnt--;
            end else if (!quiet && $urandom_range(0, 6) == 0) begin
                stall_cnt = $urandom_range(1, 10);
            end
            i_stall <= (stall_cnt > 0);
        end
    end

    function automatic logic signed [31:0] rand_value();
        logic [31:0] v;
        v = $urandom;
        if ($urandom_range(0, 1)) v = 32'($signed(v[21:0]));
        return v;
    endfunction

    function automatic t_item make_load(logic [3:0] ch);
        t_item it;
        it.op = OpLoad;
        it.ch = ch;
        it.amp = rand_value();
        it.rate = 24'($urandom);
        it.phase_step = 19'($urandom);
        it.offset = rand_value();
        return it;
    endfunction

    function automatic t_item make_tick();
        t_item it;
        it = make_load(4'($urandom));
        it.op = OpTick;
        return it;
    endfunction

    task automatic push_random(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) < 6)
                queue_stim(make_load($urandom_range(0, 9) == 0 ?
                           4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9))));
            else
                queue_stim(make_tick());
        end
    endtask

    task automatic wait_idle();
        while (stim_q.size() > 0 || i_valid || targets_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CfgMinLength:    min_len = longint'($signed(data));
            CfgMaxLength:    max_len = longint'($signed(data));
            CfgTimeStep:     step_time = data;
            CfgClusterCount: restart_ch = data[3:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [31:0] lo, logic [31:0] hi, logic [31:0] dt,
                             logic [3:0] cc);
        write_reg(CfgMinLength, lo);
        write_reg(CfgMaxLength, hi);
        write_reg(CfgTimeStep, dt);
        write_reg(CfgClusterCount, 32'(cc));
    endtask

    initial begin
        t_item it;
        reset_model();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes on the default settings
        it = make_load(4'd0);
        it.amp = 32'sh7fffffff; it.rate = 24'hffffff;
        it.phase_step = 19'sh3ffff; it.offset = '0;
        queue_stim(it);
        it = make_load(4'd1);
        it.amp = 32'sh80000000; it.rate = '0;
        it.phase_step = 19'sh40000; it.offset = 32'sh80000000;
        queue_stim(it);
        it = make_load(4'd2);
        it.amp = '0; it.offset = 32'sh7fffffff;
        queue_stim(it);
        for (int c = 3; c < NCH; c++) queue_stim(make_load(4'(c)));
        queue_stim(make_load(4'd10));
        queue_stim(make_load(4'd15));
        for (int i = 0; i < 4; i++) queue_stim(make_tick());
        push_random(30);
        // let the results drain before sending more
        while (stim_q.size() > 10) @(posedge i_clk);
        hold = 1'b1;
        while (i_valid || targets_q.size() > 0) @(posedge i_clk);
        hold = 1'b0;
        wait_idle();

        // widest limits, largest step, restart at channel zero
        configure(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 4'd0);
        push_random(40);
        wait_idle();

        // inverted limits, frozen angles, no restart
        configure(32'h7fff_ffff, 32'h8000_0000, 32'h0, 4'd15);
        push_random(20);
        wait_idle();

        configure(32'($signed(-($urandom_range(1, 1 << 22)))), 32'($urandom_range(1, 1 << 22)),
                  $urandom, 4'($urandom_range(1, 10)));
        push_random(40);
        wait_idle();

        quiet = 1'b1;
        configure(32'($signed(-($urandom_range(1, 1 << 24)))), $urandom_range(1, 1 << 24),
                  $urandom_range(0, 1 << 28), 4'($urandom_range(0, 15)));
        push_random(40);
        wait_idle();

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
